// File: rtl/core/kdeq_pkg.sv
`timescale 1ns / 1ps

package kdeq_pkg;

   localparam int KEY_COUNT  = 5;
   localparam int PIN_COUNT  = 8;
   localparam int PIN_SEL_W  = 4;
   localparam int EVENT_W    = 3;
   localparam int TIME_W     = 32;
   localparam int LOCKOUT_W  = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int OPCODE_W   = 2;
   localparam int REQ_DATA_W = PIN_COUNT + TIME_W;

   localparam logic [EVENT_W-1:0] EVENT_NONE = '0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_READ   = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_UP_PIN    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DOWN_PIN  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_LEFT_PIN  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_RIGHT_PIN = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENTER_PIN = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_LOCKOUT   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_REPORT_EN = 3'd6;

   typedef struct packed {
      logic [KEY_COUNT-1:0][PIN_SEL_W-1:0] pin;
      logic [LOCKOUT_W-1:0]                lockout;
      logic                                report_en;
   } cfg_type;

   typedef struct packed {
      logic                 push;
      logic                 pop;
      logic                 flush;
      logic [KEY_COUNT-1:0] press;
   } queue_cmd_type;

endpackage

// File: rtl/core/kdeq_ram.sv
`timescale 1ns / 1ps

module kdeq_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/kdeq_keys.sv
`timescale 1ns / 1ps

module kdeq_keys
   import kdeq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 sample_en,
   input  logic [PIN_COUNT-1:0] pins,
   input  logic [TIME_W-1:0]    now_ms,
   input  cfg_type              cfg,
   output logic [KEY_COUNT-1:0] press
);

   logic [TIME_W-1:0]    time_ff  [KEY_COUNT];
   logic [TIME_W-1:0]    time_in  [KEY_COUNT];
   logic [KEY_COUNT-1:0] level_ff;
   logic [KEY_COUNT-1:0] level_in;
   logic [KEY_COUNT-1:0] change;
   logic [KEY_COUNT-1:0] level_now;

   always_comb begin
      logic [TIME_W-1:0] elapsed;
      logic              locked;
      elapsed = '0;
      locked  = 1'b0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         level_now[k] = pins[cfg.pin[k][PIN_SEL_W-2:0]];
         elapsed      = now_ms - time_ff[k];
         locked       = (elapsed <= TIME_W'(cfg.lockout));
         change[k]    = !cfg.pin[k][PIN_SEL_W-1] && !locked && (level_now[k] != level_ff[k]);
         press[k]     = sample_en && change[k] && !level_now[k] && cfg.report_en;
         time_in[k]   = (sample_en && change[k]) ? now_ms : time_ff[k];
         level_in[k]  = (sample_en && change[k]) ? level_now[k] : level_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            time_ff[k] <= '0;
         end
         level_ff <= '1;
      end else begin
         for (int k = 0; k < KEY_COUNT; k++) begin
            time_ff[k] <= time_in[k];
         end
         level_ff <= level_in;
      end
   end

endmodule

// File: rtl/core/kdeq_queue.sv
`timescale 1ns / 1ps

module kdeq_queue
   import kdeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8,
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1),
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  queue_cmd_type      cmd,
   output logic [EVENT_W-1:0] key_event,
   output logic [COUNT_W-1:0] fill_next
);

   logic [COUNT_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0]   mem_cnt_ff, mem_cnt_in;
   logic [KEY_COUNT-1:0] head_ff, head_in;
   logic [AW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic                 byp_ff, byp_in;
   logic [KEY_COUNT-1:0] byp_data_ff;
   logic                 ram_we;
   logic [KEY_COUNT-1:0] ram_rdata;
   logic [KEY_COUNT-1:0] next_entry;
   logic [KEY_COUNT-1:0] kept;
   logic [COUNT_W-1:0]   kept_cnt;
   logic [KEY_COUNT-1:0] low_bit;
   logic [EVENT_W-1:0]   low_idx;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] ptr);
      ptr_next = (ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : ptr + AW'(1);
   endfunction

   kdeq_ram #(
      .WIDTH(KEY_COUNT),
      .DEPTH(QUEUE_DEPTH)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(wr_ptr_ff),
      .wdata(kept),
      .raddr(rd_ptr_in),
      .rdata(ram_rdata)
   );

   assign next_entry = byp_ff ? byp_data_ff : ram_rdata;

   // keep presses in key order until the queue is full
   always_comb begin
      logic [COUNT_W-1:0] space;
      space    = COUNT_W'(QUEUE_DEPTH) - fill_ff;
      kept     = '0;
      kept_cnt = '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
         if (cmd.press[k] && (kept_cnt < space)) begin
            kept[k]  = 1'b1;
            kept_cnt = kept_cnt + COUNT_W'(1);
         end
      end
   end

   always_comb begin
      low_idx = '0;
      low_bit = '0;
      for (int k = KEY_COUNT - 1; k >= 0; k--) begin
         if (head_ff[k]) begin
            low_idx = EVENT_W'(k);
         end
      end
      low_bit[low_idx] = 1'b1;
   end

   always_comb begin
      fill_in    = fill_ff;
      mem_cnt_in = mem_cnt_ff;
      head_in    = head_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      ram_we     = 1'b0;
      key_event  = EVENT_NONE;
      if (cmd.flush) begin
         fill_in    = '0;
         mem_cnt_in = '0;
         head_in    = '0;
         rd_ptr_in  = '0;
         wr_ptr_in  = '0;
      end else if (cmd.pop) begin
         if (fill_ff != '0) begin
            key_event = low_idx + EVENT_W'(1);
            fill_in   = fill_ff - COUNT_W'(1);
            head_in   = head_ff & ~low_bit;
            if (head_in == '0 && mem_cnt_ff != '0) begin
               head_in    = next_entry;
               rd_ptr_in  = ptr_next(rd_ptr_ff);
               mem_cnt_in = mem_cnt_ff - COUNT_W'(1);
            end
         end
      end else if (cmd.push) begin
         if (kept != '0) begin
            fill_in = fill_ff + kept_cnt;
            if (fill_ff == '0) begin
               head_in = kept;
            end else begin
               ram_we     = 1'b1;
               wr_ptr_in  = ptr_next(wr_ptr_ff);
               mem_cnt_in = mem_cnt_ff + COUNT_W'(1);
            end
         end
      end
      byp_in = ram_we && (wr_ptr_ff == rd_ptr_in);
   end

   assign fill_next = fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         mem_cnt_ff <= '0;
         head_ff    <= '0;
         rd_ptr_ff  <= '0;
         wr_ptr_ff  <= '0;
         byp_ff     <= 1'b0;
      end else begin
         fill_ff    <= fill_in;
         mem_cnt_ff <= mem_cnt_in;
         head_ff    <= head_in;
         rd_ptr_ff  <= rd_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
         byp_ff     <= byp_in;
      end
      byp_data_ff <= kept;
   end

endmodule

// File: rtl/core/keypad_debounce_event_queue_core.sv
`timescale 1ns / 1ps
// Keypad debounce with a key press event queue.
// req channel: one operation per transfer, kind in req_tuser (sample, read, flush).
//   A sample compares the five key pins against their stored levels; a key that
//   changes outside its lockout window takes the new level and time, and a press
//   becomes an event when reporting is on and the queue has room.
//   A read pops the oldest event; a flush empties the queue.
// rsp channel: exactly one result per request: popped event and queue fill.
// csr port: the user must write registers only while no request is outstanding;
//   unenforced by the block. The registered result shows in the cycle after the
//   transfer. One request per cycle unless stalled; key checks and queue update
//   finish in the transfer cycle; queue entries (one press mask per sample) sit in
//   RAM whose registered read prefetch and bypass keep ahead of the head register.
// Reset: keys released with change time zero, queue empty, registers to defaults.
// Stall: while rsp_tready is low a result holds and req_tready falls; it rises
//   again in the cycle the waiting result transfers.
module keypad_debounce_event_queue_core
   import kdeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8,
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_W = ((EVENT_W + COUNT_W + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // port_pins, now_ms
   input  logic [OPCODE_W-1:0]   req_tuser,  // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,  // key_event, queued_count
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type            cfg_ff, cfg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic               accept;
   queue_cmd_type      cmd;
   logic               sample_en;
   logic [KEY_COUNT-1:0] press;
   logic [EVENT_W-1:0] key_event;
   logic [COUNT_W-1:0] fill_next;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_UP_PIN:    cfg_in.pin[0]    = csr_wdata[PIN_SEL_W-1:0];
            CSR_DOWN_PIN:  cfg_in.pin[1]    = csr_wdata[PIN_SEL_W-1:0];
            CSR_LEFT_PIN:  cfg_in.pin[2]    = csr_wdata[PIN_SEL_W-1:0];
            CSR_RIGHT_PIN: cfg_in.pin[3]    = csr_wdata[PIN_SEL_W-1:0];
            CSR_ENTER_PIN: cfg_in.pin[4]    = csr_wdata[PIN_SEL_W-1:0];
            CSR_LOCKOUT:   cfg_in.lockout   = csr_wdata[LOCKOUT_W-1:0];
            CSR_REPORT_EN: cfg_in.report_en = csr_wdata[0];
            default:       cfg_in           = cfg_ff;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      sample_en = 1'b0;
      cmd       = '0;
      if (accept) begin
         unique case (op_type'(req_tuser))
            OP_SAMPLE: begin
               sample_en = 1'b1;
               cmd.push  = 1'b1;
            end
            OP_READ:  cmd.pop   = 1'b1;
            OP_FLUSH: cmd.flush = 1'b1;
            default:  cmd       = '0;
         endcase
      end
      cmd.press = press;
   end

   kdeq_keys u_keys (
      .clock    (clock),
      .reset    (reset),
      .sample_en(sample_en),
      .pins     (req_tdata[PIN_COUNT-1:0]),
      .now_ms   (req_tdata[PIN_COUNT +: TIME_W]),
      .cfg      (cfg_ff),
      .press    (press)
   );

   kdeq_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .key_event(key_event),
      .fill_next(fill_next)
   );

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_tready);
   assign rsp_data_in  = accept ? RSP_W'({fill_next, key_event}) : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff      <= 1'b0;
         cfg_ff.pin[0]     <= PIN_SEL_W'(0);
         cfg_ff.pin[1]     <= PIN_SEL_W'(1);
         cfg_ff.pin[2]     <= PIN_SEL_W'(2);
         cfg_ff.pin[3]     <= PIN_SEL_W'(3);
         cfg_ff.pin[4]     <= PIN_SEL_W'(4);
         cfg_ff.lockout    <= LOCKOUT_W'(20);
         cfg_ff.report_en  <= 1'b1;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: rtl/core/kdeq_checker.sv
`timescale 1ns / 1ps

module kdeq_checker
   import kdeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8,
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1),
   localparam int RSP_W = ((EVENT_W + COUNT_W + 7) / 8) * 8
) (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic [OPCODE_W-1:0] req_tuser,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [RSP_W-1:0]    rsp_tdata
);

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[EVENT_W-1:0] <= EVENT_W'(KEY_COUNT))
      else $error("key event code out of range");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[EVENT_W +: COUNT_W] <= COUNT_W'(QUEUE_DEPTH))
      else $error("queued count above queue depth");

   a_flush_empty: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_FLUSH) |=>
         (rsp_tvalid && rsp_tdata[EVENT_W +: COUNT_W] == '0
          && rsp_tdata[EVENT_W-1:0] == EVENT_NONE))
      else $error("flush result does not show an empty queue");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or dropped");

endmodule

bind keypad_debounce_event_queue_core kdeq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_kdeq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

// File: tb/keypad_event_checker.sv
`timescale 1ns / 1ps

module keypad_event_checker
   import kdeq_pkg::*;
#(
   parameter int RSP_W = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // port_pins, now_ms
   input  logic [OPCODE_W-1:0]   req_tuser,  // opcode
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_W-1:0]      rsp_tdata,  // key_event, queued_count
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    outstanding
);

   localparam int RING_DEPTH = 8;
   localparam int FILL_W = 4;

   typedef struct packed {
      logic [FILL_W-1:0]  queued_count;
      logic [EVENT_W-1:0] key_event;
   } key_status_type;

   logic [PIN_SEL_W-1:0] pin_sel [KEY_COUNT];
   logic [LOCKOUT_W-1:0] lockout;
   logic                 report_en;
   logic [TIME_W-1:0]    change_time [KEY_COUNT];
   logic                 key_released [KEY_COUNT];
   logic [EVENT_W-1:0]   event_ring [RING_DEPTH];
   logic [2:0]           ring_head;
   logic [FILL_W-1:0]    ring_fill;
   key_status_type       predicted_status [$];
   key_status_type       want;
   key_status_type       got;
   int                   fails = 0;
   int                   waiting = 0;

   assign error_count = fails;
   assign outstanding = waiting;

   task automatic restore_defaults();
      for (int k = 0; k < KEY_COUNT; k++) begin
         pin_sel[k] = PIN_SEL_W'(k);
         change_time[k] = '0;
         key_released[k] = 1'b1;
      end
      lockout = 16'd20;
      report_en = 1'b1;
      ring_head = '0;
      ring_fill = '0;
      predicted_status.delete();
   endtask

   task automatic debounce_and_queue(input logic [OPCODE_W-1:0] op,
                                     input logic [PIN_COUNT-1:0] pins,
                                     input logic [TIME_W-1:0] now,
                                     output key_status_type st);
      logic [PIN_SEL_W-1:0] sel;
      logic                 level;
      logic [TIME_W-1:0]    elapsed;
      logic [2:0]           slot;
      st.key_event = EVENT_NONE;
      case (op)
         OP_SAMPLE: begin
            for (int k = 0; k < KEY_COUNT; k++) begin
               sel = pin_sel[k];
               level = pins[sel[2:0]];
               elapsed = now - change_time[k];
               if (!sel[PIN_SEL_W-1] && elapsed > TIME_W'(lockout)
                   && level != key_released[k]) begin
                  change_time[k] = now;
                  key_released[k] = level;
                  if (!level && report_en && ring_fill < RING_DEPTH) begin
                     slot = ring_head + ring_fill[2:0];
                     event_ring[slot] = EVENT_W'(k + 1);
                     ring_fill = ring_fill + 1'b1;
                  end
               end
            end
         end
         OP_READ: begin
            if (ring_fill != 0) begin
               st.key_event = event_ring[ring_head];
               ring_head = ring_head + 1'b1;
               ring_fill = ring_fill - 1'b1;
            end
         end
         OP_FLUSH: begin
            ring_head = '0;
            ring_fill = '0;
         end
         default: ;
      endcase
      st.queued_count = ring_fill;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_defaults();
      end else begin
         if (csr_we) begin
            case (csr_addr) inside
               CSR_UP_PIN, CSR_DOWN_PIN, CSR_LEFT_PIN, CSR_RIGHT_PIN, CSR_ENTER_PIN:
                  pin_sel[csr_addr] = csr_wdata[PIN_SEL_W-1:0];
               CSR_LOCKOUT:   lockout = csr_wdata[LOCKOUT_W-1:0];
               CSR_REPORT_EN: report_en = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            debounce_and_queue(req_tuser, req_tdata[PIN_COUNT-1:0],
                               req_tdata[PIN_COUNT +: TIME_W], want);
            predicted_status.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.key_event = rsp_tdata[EVENT_W-1:0];
            got.queued_count = rsp_tdata[EVENT_W +: FILL_W];
            if (predicted_status.size() == 0) begin
               $error("rsp transfer with nothing predicted: key_event %0d queued_count %0d",
                      got.key_event, got.queued_count);
               fails++;
            end else begin
               want = predicted_status.pop_front();
               if (got.key_event !== want.key_event) begin
                  $error("key_event: expected %0d, actual %0d", want.key_event,
                         got.key_event);
                  fails++;
               end
               if (got.queued_count !== want.queued_count) begin
                  $error("queued_count: expected %0d, actual %0d", want.queued_count,
                         got.queued_count);
                  fails++;
               end
            end
         end
      end
      waiting = predicted_status.size();
   end

endmodule

// File: tb/keypad_debounce_event_queue_core_tb.sv
`timescale 1ns / 1ps

module keypad_debounce_event_queue_core_tb;
   import kdeq_pkg::*;

   localparam int RSP_W = 8;
   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [PIN_SEL_W-1:0] PIN_NONE = 4'hF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // port_pins, now_ms
   logic [OPCODE_W-1:0]   req_tuser;  // opcode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;  // key_event, queued_count
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    error_count;
   int                    outstanding;

   int                    send_gap_pct = 0;
   int                    rsp_stall_pct = 0;
   int                    hold_phase = 0;
   int                    hold_seen = 0;
   int                    hold_left = 0;
   int                    read_pct = 30;
   int                    cur_lockout = 20;
   logic [TIME_W-1:0]     now_ms = '0;
   logic [PIN_COUNT-1:0]  pin_state = 8'hFF;

   keypad_debounce_event_queue_core u_top (.*);

   keypad_event_checker #(.RSP_W(RSP_W)) u_checker (.*);

   always #10 clock = ~clock;

   always @(negedge clock) begin
      if (hold_phase != hold_seen) begin
         hold_seen = hold_phase;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [PIN_COUNT-1:0] pins,
                          input logic [TIME_W-1:0] now);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {now, pins};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [PIN_SEL_W-1:0] up_sel, down_sel, left_sel,
                            right_sel, enter_sel, input logic [LOCKOUT_W-1:0] lock,
                            input logic en);
      quiesce();
      csr_write(CSR_UP_PIN, CSR_DATA_W'(up_sel));
      csr_write(CSR_DOWN_PIN, CSR_DATA_W'(down_sel));
      csr_write(CSR_LEFT_PIN, CSR_DATA_W'(left_sel));
      csr_write(CSR_RIGHT_PIN, CSR_DATA_W'(right_sel));
      csr_write(CSR_ENTER_PIN, CSR_DATA_W'(enter_sel));
      csr_write(CSR_LOCKOUT, CSR_DATA_W'(lock));
      csr_write(CSR_REPORT_EN, CSR_DATA_W'(en));
      cur_lockout = lock;
   endtask

   function automatic logic [PIN_SEL_W-1:0] rand_sel();
      return ($urandom_range(8) == 8) ? PIN_NONE : PIN_SEL_W'($urandom_range(7));
   endfunction

   task automatic random_item();
      int r;
      logic [OPCODE_W-1:0] op;
      r = $urandom_range(99);
      if (r < 10) now_ms = $urandom;
      else if (r < 30) now_ms = now_ms + $urandom_range(3);
      else now_ms = now_ms + $urandom_range(2 * cur_lockout + 4);
      pin_state = pin_state ^ PIN_COUNT'($urandom & $urandom);
      r = $urandom_range(99);
      if (r < 92 - read_pct) op = OP_SAMPLE;
      else if (r < 92) op = OP_READ;
      else if (r < 96) op = OP_FLUSH;
      else op = OP_UNUSED;
      send_op(op, pin_state, now_ms);
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_op(OP_READ, 8'h00, 32'd0);
      send_op(OP_SAMPLE, 8'h00, 32'd0);
      send_op(OP_SAMPLE, 8'h00, 32'd21);
      send_op(OP_SAMPLE, 8'hFF, 32'd30);
      send_op(OP_SAMPLE, 8'hFF, 32'd42);
      send_op(OP_SAMPLE, 8'h00, 32'd64);
      send_op(OP_READ, 8'hFF, 32'hFFFF_FFFF);
      send_op(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
      send_op(OP_FLUSH, 8'h55, 32'h8000_0000);
      send_op(OP_READ, 8'hAA, 32'h7FFF_FFFF);
      configure(4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 16'd20, 1'b0);
      send_op(OP_SAMPLE, 8'hFF, 32'd100);
      send_op(OP_SAMPLE, 8'h00, 32'd200);
      configure(PIN_NONE, 4'd7, 4'd5, 4'd6, 4'd7, 16'hFFFF, 1'b1);
      send_op(OP_SAMPLE, 8'hFF, 32'd65736);
      send_op(OP_SAMPLE, 8'h00, 32'd131271);
      send_op(OP_SAMPLE, 8'h00, 32'hFFFF_FFFF);
      send_op(OP_READ, 8'h00, 32'd1);
      send_op(OP_READ, 8'h00, 32'd2);
      send_op(OP_SAMPLE, 8'hFF, 32'd5);
      send_op(OP_SAMPLE, 8'hFF, 32'd65540);
      now_ms = 32'd65540;

      for (int seg = 0; seg < 7; seg++) begin
         case (seg)
            0: configure(4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 16'd20, 1'b1);
            1: configure(4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 16'd0, 1'b1);
            2: configure(PIN_NONE, 4'd7, PIN_NONE, 4'd0, 4'd7, 16'hFFFF, 1'b1);
            3: configure(4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 16'd5, 1'b0);
            4: configure(rand_sel(), rand_sel(), rand_sel(), rand_sel(), rand_sel(),
                         LOCKOUT_W'($urandom_range(60)), 1'($urandom_range(1)));
            5: configure(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 16'd1, 1'b1);
            default: configure(4'd2, PIN_NONE, 4'd6, 4'd1, 4'd3, 16'd40, 1'b1);
         endcase
         case (seg % 4)
            0: begin send_gap_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_gap_pct = 86; rsp_stall_pct <= 0;  end
            2: begin send_gap_pct = 0;  rsp_stall_pct <= 86; end
            default: begin send_gap_pct = 8; rsp_stall_pct <= 8; end
         endcase
         read_pct = (seg % 2) ? 15 : 32;
         if (seg == 2) hold_phase <= hold_phase + 1;
         for (int i = 0; i < 150; i++) begin
            if (seg == 3 && i == 75) quiesce();
            random_item();
         end
      end

      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (error_count == 0) $display("keypad_debounce_event_queue_core: match");
      else $display("keypad_debounce_event_queue_core: mismatch");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("keypad_debounce_event_queue_core: mismatch");
      $finish;
   end

endmodule
